@@ hw/rtl/voce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voce_pkg
// Shared constants, types and exponential tables for the Voce hardening
// evaluator.
// ----------------------------------------------------------------------------
package voce_pkg;

    // Fractional exponential table depth, a power of two
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int EXP_ADDR_W        = $clog2(EXP_TABLE_ENTRIES);
    // Width of the reduced residual r (Q30, below one table step)
    localparam int EXP_R_W           = 30 - EXP_ADDR_W;
    localparam int EXP_INT_DEPTH     = 33;
    localparam int EXP_INT_AW        = $clog2(EXP_INT_DEPTH);

    localparam logic [63:0] ONE_Q60  = 64'd1 << 60;
    localparam logic [30:0] ONE_Q30  = 31'd1 << 30;
    localparam logic [61:0] RND_Q30  = 62'd1 << 29;
    localparam logic [16:0] THETA_ONE = 17'd65536;

    // Signed accumulator width for the final sums
    localparam int SUM_W = 68;

    // Pipeline stages
    localparam int NSTG     = 12;
    localparam int ST_X     = 0;   // exponent * strain
    localparam int ST_ROM   = 1;   // range reduction, table reads, r*r
    localparam int ST_EPROD = 2;   // EI*EF, polynomial p
    localparam int ST_E1    = 3;   // round EI*EF
    localparam int ST_EP    = 4;   // e1*p
    localparam int ST_E     = 5;   // round to E
    localparam int ST_DPROD = 6;   // |D|*E and |D|*(1-E) partials
    localparam int ST_DTERM = 7;   // round both
    localparam int ST_XPROD = 8;   // rnd(|D|E)*exponent partials
    localparam int ST_XTERM = 9;   // round
    localparam int ST_SUM   = 10;  // signed sums
    localparam int ST_OUT   = 11;  // clamp, output register

    typedef enum logic [2:0] {
        REG_YIELD    = 3'd0,
        REG_LINEAR   = 3'd1,
        REG_REF      = 3'd2,
        REG_INF      = 3'd3,
        REG_EXPONENT = 3'd4,
        REG_THETA    = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic signed [47:0] y;     // yield stress
        logic [31:0]        d;     // hardening exponent, Q16.16
        logic [16:0]        thc;   // theta clamped to one
        logic [16:0]        thi;   // one - theta
        logic [47:0]        hm;    // |H|
        logic               hn;    // H negative
        logic [48:0]        dm;    // |Kinf - Kref|
        logic               dn;    // Kinf - Kref negative
    } voce_cfg_t;

    typedef struct packed {
        logic [NSTG-1:0] en;       // stage load enable
        logic [NSTG-1:0] vld;      // stage holds an item
    } voce_pipe_t;

    typedef logic [30:0] q30_t;
    typedef q30_t exp_int_rom_t  [0:EXP_INT_DEPTH-1];
    typedef q30_t exp_frac_rom_t [0:EXP_TABLE_ENTRIES-1];

    // exp(-num/N) in Q60 by a 24-term Taylor series, num <= N;
    // N is a power of two, so t/(N*k) is (t >> log2 N)/k
    function automatic logic [63:0] exp_frac_q60(input logic [63:0] num);
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        t = ONE_Q60; pos = ONE_Q60; neg = '0;
        t = (t >> EXP_ADDR_W) / 64'd1  * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd2  * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd3  * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd4  * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd5  * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd6  * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd7  * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd8  * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd9  * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd10 * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd11 * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd12 * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd13 * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd14 * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd15 * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd16 * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd17 * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd18 * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd19 * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd20 * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd21 * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd22 * num; pos = pos + t;
        t = (t >> EXP_ADDR_W) / 64'd23 * num; neg = neg + t;
        t = (t >> EXP_ADDR_W) / 64'd24 * num; pos = pos + t;
        return pos - neg;
    endfunction

    // exp(-1) in Q60, same series
    function automatic logic [63:0] exp_one_q60();
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        t = ONE_Q60; pos = ONE_Q60; neg = '0;
        t = t / 64'd1;  neg = neg + t;
        t = t / 64'd2;  pos = pos + t;
        t = t / 64'd3;  neg = neg + t;
        t = t / 64'd4;  pos = pos + t;
        t = t / 64'd5;  neg = neg + t;
        t = t / 64'd6;  pos = pos + t;
        t = t / 64'd7;  neg = neg + t;
        t = t / 64'd8;  pos = pos + t;
        t = t / 64'd9;  neg = neg + t;
        t = t / 64'd10; pos = pos + t;
        t = t / 64'd11; neg = neg + t;
        t = t / 64'd12; pos = pos + t;
        t = t / 64'd13; neg = neg + t;
        t = t / 64'd14; pos = pos + t;
        t = t / 64'd15; neg = neg + t;
        t = t / 64'd16; pos = pos + t;
        t = t / 64'd17; neg = neg + t;
        t = t / 64'd18; pos = pos + t;
        t = t / 64'd19; neg = neg + t;
        t = t / 64'd20; pos = pos + t;
        t = t / 64'd21; neg = neg + t;
        t = t / 64'd22; pos = pos + t;
        t = t / 64'd23; neg = neg + t;
        t = t / 64'd24; pos = pos + t;
        return pos - neg;
    endfunction

    // Product of two Q60 values no larger than one
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a1;
        logic [63:0] a0;
        logic [63:0] b1;
        logic [63:0] b0;
        a1 = a >> 30; a0 = a & 64'h3FFF_FFFF;
        b1 = b >> 30; b0 = b & 64'h3FFF_FFFF;
        return a1 * b1 + ((a1 * b0 + a0 * b1 + ((a0 * b0) >> 30)) >> 30);
    endfunction

    function automatic exp_int_rom_t build_int_rom();
        exp_int_rom_t rom;
        logic [63:0]  cur;
        logic [63:0]  e1;
        cur = ONE_Q60;
        e1  = exp_one_q60();
        for (int k = 0; k < EXP_INT_DEPTH; k++) begin
            rom[k] = 31'((cur + (64'd1 << 29)) >> 30);
            cur    = mul_q60(cur, e1);
        end
        return rom;
    endfunction

    function automatic exp_frac_rom_t build_frac_rom();
        exp_frac_rom_t rom;
        for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
            rom[k] = 31'((exp_frac_q60(64'(k)) + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    // exp(-n), n = 0..32, and exp(-i/N), Q30
    localparam exp_int_rom_t  EXP_INT_ROM  = build_int_rom();
    localparam exp_frac_rom_t EXP_FRAC_ROM = build_frac_rom();

endpackage

@@ hw/rtl/voce_ctl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voce_ctl
// Stage valid bits and per-stage load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module voce_ctl import voce_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       m_tready,
    output logic       s_tready,
    output voce_pipe_t pipe
);

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    // a stage loads when it is empty or its successor moves on
    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign pipe.en  = en;
    assign pipe.vld = vld_reg;

    a_free_out_opens_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !vld_reg[NSTG-1]) |-> s_tready)
        else $error("input blocked although the output side can move");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transfer did not enter the first stage");

    a_held_stage_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((vld_reg & $past(vld_reg & ~en)) == $past(vld_reg & ~en)))
        else $error("stalled stage lost its item");

endmodule

@@ hw/rtl/voce_exp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voce_exp
// E = exp(-exponent*strain) in Q30 by table lookup and range reduction.
// ----------------------------------------------------------------------------
module voce_exp import voce_pkg::*; (
    input  logic        aclk,
    input  voce_pipe_t  pipe,
    input  voce_cfg_t   cfg,
    input  logic [31:0] strain,
    output logic [31:0] strain_x,   // strain held at the first stage
    output logic [30:0] e_q30       // E at its stage
);

    localparam logic [63:0] X_LIMIT = 64'd32 << 40;

    logic [63:0]              x_reg;
    logic [31:0]              str_reg;
    logic                     inr1_reg, inr2_reg, inr3_reg, inr4_reg;
    logic [30:0]              ei_reg, ef_reg;
    logic [2*EXP_R_W-1:0]     rr_reg;
    logic [EXP_R_W-1:0]       r_reg;
    logic [61:0]              eprod_reg;
    logic [30:0]              p_reg, p3_reg;
    logic [30:0]              e1_reg;
    logic [61:0]              ep_reg;
    logic [30:0]              e_reg;

    logic                     inr;
    logic [EXP_INT_AW-1:0]    n_idx;
    logic [EXP_ADDR_W-1:0]    f_idx;
    logic [EXP_R_W-1:0]       r;

    // x = n + f: integer part, table step, residual below one step
    always_comb begin
        inr   = (x_reg <= X_LIMIT);
        n_idx = inr ? x_reg[40 +: EXP_INT_AW] : '0;
        f_idx = x_reg[39 -: EXP_ADDR_W];
        r     = x_reg[39-EXP_ADDR_W:10];
    end

    always_ff @(posedge aclk) begin
        if (pipe.en[ST_X]) begin
            x_reg   <= 64'(cfg.d) * 64'(strain);
            str_reg <= strain;
        end
        if (pipe.en[ST_ROM]) begin
            ei_reg   <= EXP_INT_ROM[n_idx];
            ef_reg   <= EXP_FRAC_ROM[f_idx];
            rr_reg   <= (2*EXP_R_W)'(r) * (2*EXP_R_W)'(r);
            r_reg    <= r;
            inr1_reg <= inr;
        end
        if (pipe.en[ST_EPROD]) begin
            eprod_reg <= 62'(ei_reg) * 62'(ef_reg);
            // p = 1 - r + r^2/2, second-order correction
            p_reg     <= ONE_Q30 - 31'(r_reg) + 31'(rr_reg >> 31);
            inr2_reg  <= inr1_reg;
        end
        if (pipe.en[ST_E1]) begin
            e1_reg   <= 31'((eprod_reg + RND_Q30) >> 30);
            p3_reg   <= p_reg;
            inr3_reg <= inr2_reg;
        end
        if (pipe.en[ST_EP]) begin
            ep_reg   <= 62'(e1_reg) * 62'(p3_reg);
            inr4_reg <= inr3_reg;
        end
        if (pipe.en[ST_E]) begin
            e_reg <= inr4_reg ? 31'((ep_reg + RND_Q30) >> 30) : '0;
        end
    end

    assign strain_x = str_reg;
    assign e_q30    = e_reg;

    a_e_in_range: assert property (@(posedge aclk)
        pipe.vld[ST_E] |-> (e_reg <= ONE_Q30))
        else $error("E above one");

endmodule

@@ hw/rtl/voce_lin.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voce_lin
// Linear terms: theta*|H|*s, theta*|H| and (1-theta)*|H|, rounded.
// ----------------------------------------------------------------------------
module voce_lin import voce_pkg::*; (
    input  logic        aclk,
    input  voce_pipe_t  pipe,
    input  voce_cfg_t   cfg,
    input  logic [31:0] strain_x,
    output logic [56:0] ths_mag,    // rnd(theta*|H|*s / 2^40)
    output logic [48:0] th_mag,     // rnd(theta*|H| / 2^16)
    output logic [48:0] kin_mag     // rnd((1-theta)*|H| / 2^16)
);

    localparam logic [96:0] RND40 = 97'd1 << 39;
    localparam logic [64:0] RND16 = 65'd1 << 15;

    logic [63:0] thh_reg, thih_reg;
    logic [31:0] str1_reg;
    logic [63:0] ph_reg, pl_reg;

    logic [48:0] thd_reg  [ST_EPROD:ST_XTERM];
    logic [48:0] kind_reg [ST_EPROD:ST_XTERM];
    logic [56:0] ad_reg   [ST_E1:ST_XTERM];

    always_ff @(posedge aclk) begin
        if (pipe.en[ST_ROM]) begin
            thh_reg  <= 64'(cfg.thc) * 64'(cfg.hm);
            thih_reg <= 64'(cfg.thi) * 64'(cfg.hm);
            str1_reg <= strain_x;
        end
        if (pipe.en[ST_EPROD]) begin
            // 64x32 split into two 32x32 partials
            ph_reg             <= 64'(thh_reg[63:32]) * 64'(str1_reg);
            pl_reg             <= 64'(thh_reg[31:0]) * 64'(str1_reg);
            thd_reg[ST_EPROD]  <= 49'((65'(thh_reg) + RND16) >> 16);
            kind_reg[ST_EPROD] <= 49'((65'(thih_reg) + RND16) >> 16);
        end
        if (pipe.en[ST_E1]) begin
            ad_reg[ST_E1] <= 57'(({1'b0, ph_reg, 32'd0} + 97'(pl_reg) + RND40) >> 40);
        end
        for (int k = ST_EPROD + 1; k <= ST_XTERM; k++) begin
            if (pipe.en[k]) begin
                thd_reg[k]  <= thd_reg[k-1];
                kind_reg[k] <= kind_reg[k-1];
            end
        end
        for (int k = ST_E1 + 1; k <= ST_XTERM; k++) begin
            if (pipe.en[k]) begin
                ad_reg[k] <= ad_reg[k-1];
            end
        end
    end

    assign ths_mag = ad_reg[ST_XTERM];
    assign th_mag  = thd_reg[ST_XTERM];
    assign kin_mag = kind_reg[ST_XTERM];

endmodule

@@ hw/rtl/voce_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voce_sum
// Saturation terms from E, signed sums and clamping to 48 bits.
// ----------------------------------------------------------------------------
module voce_sum import voce_pkg::*; (
    input  logic               aclk,
    input  voce_pipe_t         pipe,
    input  voce_cfg_t          cfg,
    input  logic [30:0]        e_q30,
    input  logic [56:0]        ths_mag,
    input  logic [48:0]        th_mag,
    input  logic [48:0]        kin_mag,
    output logic signed [47:0] hardening,
    output logic signed [47:0] hardening_slope,
    output logic               saturated
);

    localparam logic [79:0] RND30 = 80'd1 << 29;
    localparam logic [80:0] RND16 = 81'd1 << 15;
    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(64'sd140737488355327);
    localparam logic signed [SUM_W-1:0] OUT_MIN = -OUT_MAX - SUM_W'(1);

    logic [55:0] pa_hi_reg, pb_hi_reg;
    logic [54:0] pa_lo_reg, pb_lo_reg;
    logic [48:0] m1_reg, td7_reg, td8_reg, td9_reg;
    logic [56:0] xh_reg;
    logic [55:0] xl_reg;
    logic [64:0] x_reg;
    logic signed [SUM_W-1:0] hard_reg, slope_reg;
    logic signed [47:0]      hard_o_reg, slope_o_reg;
    logic                    sat_reg;
    logic [30:0]             ome;

    function automatic logic signed [SUM_W-1:0] signed_of(input logic neg,
                                                          input logic [SUM_W-1:0] m);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    assign ome = ONE_Q30 - e_q30;

    always_ff @(posedge aclk) begin
        if (pipe.en[ST_DPROD]) begin
            pa_hi_reg <= 56'(cfg.dm[48:24]) * 56'(e_q30);
            pa_lo_reg <= 55'(cfg.dm[23:0]) * 55'(e_q30);
            pb_hi_reg <= 56'(cfg.dm[48:24]) * 56'(ome);
            pb_lo_reg <= 55'(cfg.dm[23:0]) * 55'(ome);
        end
        if (pipe.en[ST_DTERM]) begin
            m1_reg  <= 49'(({pa_hi_reg, 24'd0} + 80'(pa_lo_reg) + RND30) >> 30);
            td7_reg <= 49'(({pb_hi_reg, 24'd0} + 80'(pb_lo_reg) + RND30) >> 30);
        end
        if (pipe.en[ST_XPROD]) begin
            xh_reg  <= 57'(m1_reg[48:24]) * 57'(cfg.d);
            xl_reg  <= 56'(m1_reg[23:0]) * 56'(cfg.d);
            td8_reg <= td7_reg;
        end
        if (pipe.en[ST_XTERM]) begin
            x_reg   <= 65'(({xh_reg, 24'd0} + 81'(xl_reg) + RND16) >> 16);
            td9_reg <= td8_reg;
        end
        if (pipe.en[ST_SUM]) begin
            hard_reg  <= {{(SUM_W-48){cfg.y[47]}}, cfg.y}
                       + signed_of(cfg.hn, SUM_W'(ths_mag))
                       + signed_of(cfg.dn, SUM_W'(td9_reg))
                       + signed_of(cfg.hn, SUM_W'(kin_mag));
            slope_reg <= signed_of(cfg.hn, SUM_W'(th_mag))
                       + signed_of(cfg.dn, SUM_W'(x_reg));
        end
        if (pipe.en[ST_OUT]) begin
            hard_o_reg  <= (hard_reg > OUT_MAX)  ? OUT_MAX[47:0] :
                           (hard_reg < OUT_MIN)  ? OUT_MIN[47:0] : hard_reg[47:0];
            slope_o_reg <= (slope_reg > OUT_MAX) ? OUT_MAX[47:0] :
                           (slope_reg < OUT_MIN) ? OUT_MIN[47:0] : slope_reg[47:0];
            sat_reg     <= (hard_reg > OUT_MAX) || (hard_reg < OUT_MIN)
                        || (slope_reg > OUT_MAX) || (slope_reg < OUT_MIN);
        end
    end

    assign hardening       = hard_o_reg;
    assign hardening_slope = slope_o_reg;
    assign saturated       = sat_reg;

endmodule

@@ hw/rtl/voce_hardening_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voce_hardening_evaluator
// Voce linear plus exponential-saturation hardening: stress and slope from
// the equivalent plastic strain, twelve-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload (lowest bit first)                   handshake
//  s_        in         plastic_strain[31:0]                         tvalid/tready
//  m_        out        hardening[47:0], hardening_slope[95:48],     tvalid/tready
//                       saturated[96], zero pad to 104
//  cfg_      in         cfg_index selects register, cfg_wdata       cfg_we, no wait
//
//  One transfer per cycle in each direction unless m_ stalls; the rate is set
//  by the twelve register stages, each holding one multiply or one round/add.
//  A result passes through every stage, ST_X first and ST_OUT last.
//  Reset (aresetn low at a clock edge) empties every stage and loads the
//  registers with zero, theta with one.
//  Stalls on m_ hold the stalled stages; empty stages ahead of them keep
//  filling, so s_tready drops only once the whole pipeline is full.
//  Derived register values (|H|, |Kinf-Kref|, clamped theta) are registered
//  and settle in the cycle after a register write.
//
module voce_hardening_evaluator import voce_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,    // [31:0] plastic_strain
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,    // [47:0] hardening, [95:48] hardening_slope,
                                     // [96] saturated, rest zero
    // register write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_wdata
);

    // programmed registers
    logic [47:0] yield_reg, linear_reg, ref_reg, inf_reg;
    logic [31:0] exponent_reg;
    logic [16:0] theta_reg;

    // values derived from them, registered
    logic [16:0] thc_reg, thi_reg;
    logic [47:0] hm_reg;
    logic        hn_reg;
    logic [48:0] dm_reg;
    logic        dn_reg;
    logic [16:0] thc_next;
    logic [48:0] dk;

    voce_cfg_t   cfg;
    voce_pipe_t  pipe;

    logic [31:0]        strain_x;
    logic [30:0]        e_q30;
    logic [56:0]        ths_mag;
    logic [48:0]        th_mag, kin_mag;
    logic signed [47:0] hardening, hardening_slope;
    logic               saturated;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yield_reg    <= '0;
            linear_reg   <= '0;
            ref_reg      <= '0;
            inf_reg      <= '0;
            exponent_reg <= '0;
            theta_reg    <= THETA_ONE;
        end else if (cfg_we) begin
            unique case (cfg_reg_e'(cfg_index))
                REG_YIELD:    yield_reg    <= cfg_wdata;
                REG_LINEAR:   linear_reg   <= cfg_wdata;
                REG_REF:      ref_reg      <= cfg_wdata;
                REG_INF:      inf_reg      <= cfg_wdata;
                REG_EXPONENT: exponent_reg <= cfg_wdata[31:0];
                REG_THETA:    theta_reg    <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // theta above one acts as one; magnitudes and signs for the datapath
    assign thc_next = (theta_reg > THETA_ONE) ? THETA_ONE : theta_reg;
    assign dk       = {inf_reg[47], inf_reg} - {ref_reg[47], ref_reg};

    always_ff @(posedge aclk) begin
        thc_reg <= thc_next;
        thi_reg <= THETA_ONE - thc_next;
        hm_reg  <= linear_reg[47] ? (~linear_reg + 48'd1) : linear_reg;
        hn_reg  <= linear_reg[47];
        dm_reg  <= dk[48] ? (~dk + 49'd1) : dk;
        dn_reg  <= dk[48];
    end

    always_comb begin
        cfg.y   = yield_reg;
        cfg.d   = exponent_reg;
        cfg.thc = thc_reg;
        cfg.thi = thi_reg;
        cfg.hm  = hm_reg;
        cfg.hn  = hn_reg;
        cfg.dm  = dm_reg;
        cfg.dn  = dn_reg;
    end

    voce_ctl u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .pipe     (pipe)
    );

    voce_exp u_exp (
        .aclk     (aclk),
        .pipe     (pipe),
        .cfg      (cfg),
        .strain   (s_tdata),
        .strain_x (strain_x),
        .e_q30    (e_q30)
    );

    voce_lin u_lin (
        .aclk     (aclk),
        .pipe     (pipe),
        .cfg      (cfg),
        .strain_x (strain_x),
        .ths_mag  (ths_mag),
        .th_mag   (th_mag),
        .kin_mag  (kin_mag)
    );

    voce_sum u_sum (
        .aclk            (aclk),
        .pipe            (pipe),
        .cfg             (cfg),
        .e_q30           (e_q30),
        .ths_mag         (ths_mag),
        .th_mag          (th_mag),
        .kin_mag         (kin_mag),
        .hardening       (hardening),
        .hardening_slope (hardening_slope),
        .saturated       (saturated)
    );

    assign m_tvalid = pipe.vld[ST_OUT];
    assign m_tdata  = {7'd0, saturated, hardening_slope, hardening};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Voce hardening evaluator. Results are compared
// field by field in order. A directed table with results written by hand
// comes first, then extreme points and randomised phases checked by a local
// bit-exact predictor, with new register settings between the phases, random
// gaps on both sides and deliberate back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import voce_pkg::*;

    localparam int LATENCY    = 11;
    localparam int CYCLE_CAP  = 1000000;
    localparam logic [63:0] CAP_MAG = 64'd1 << 62;
    localparam logic signed [63:0] OUT_HI = 64'sd140737488355327;
    localparam logic signed [63:0] OUT_LO = -64'sd140737488355328;

    typedef struct packed {
        logic [47:0] hardening;
        logic [47:0] slope;
        logic        saturated;
    } stress_t;

    typedef struct {
        logic [31:0] strain;
        logic        typed;     // expected result written in by hand
        stress_t     want;
    } strain_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [47:0]  cfg_wdata;

    voce_hardening_evaluator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Predictor copy of the register file
    logic [47:0] yield_q, linear_q, kref_q, kinf_q;
    logic [31:0] rate_q;
    logic [16:0] share_q;

    logic [63:0] int_rom  [0:32];
    logic [63:0] frac_rom [0:EXP_TABLE_ENTRIES];

    stress_t     pending_stress[$];
    int          fail_count;
    int          cycle_count;
    bit          hold_off_long;
    bit          stall_on;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // exp(-num/den) in Q60, 24-term series
    function automatic logic [63:0] series_exp(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] t, pos, neg;
        t = 64'd1 << 60; pos = t; neg = '0;
        for (int k = 1; k <= 24; k++) begin
            t = t / (den * 64'(k)) * num;
            if (k % 2 == 1) neg += t; else pos += t;
        end
        return pos - neg;
    endfunction

    function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a1, a0, b1, b0;
        a1 = a >> 30; a0 = a & 64'h3FFF_FFFF;
        b1 = b >> 30; b0 = b & 64'h3FFF_FFFF;
        return a1 * b1 + ((a1 * b0 + a0 * b1 + ((a0 * b0) >> 30)) >> 30);
    endfunction

    // round(a*b / 2^sh), ties up, capped at 2^62 (wide arithmetic suffices)
    function automatic logic [63:0] scaled_round(input logic [63:0] a, input logic [63:0] b,
                                                 input int sh);
        logic [127:0] p;
        p = (128'(a) * 128'(b) + (128'd1 << (sh - 1))) >> sh;
        return (p > 128'(CAP_MAG)) ? CAP_MAG : p[63:0];
    endfunction

    function automatic logic signed [63:0] apply_sign(input logic neg, input logic [63:0] m);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic stress_t predict_stress(input logic [31:0] strain);
        logic [63:0] x, e, n, fn, i, r, p, th, hm, dm, th_h;
        logic signed [63:0] y, h, dk, hard, slope;
        stress_t res;
        th = (share_q > 17'd65536) ? 64'd65536 : 64'(share_q);
        y  = 64'($signed(yield_q));
        h  = 64'($signed(linear_q));
        dk = 64'($signed(kinf_q)) - 64'($signed(kref_q));
        hm = h < 0 ? -h : h;
        dm = dk < 0 ? -dk : dk;
        x  = 64'(rate_q) * 64'(strain);
        e  = '0;
        if (x <= (64'd32 << 40)) begin
            n  = x >> 40;
            fn = (x & 64'hFF_FFFF_FFFF) * 64'(EXP_TABLE_ENTRIES);
            i  = fn >> 40;
            r  = ((fn & 64'hFF_FFFF_FFFF) >> 10) / 64'(EXP_TABLE_ENTRIES);
            p  = (64'd1 << 30) - r + ((r * r) >> 31);
            if (i >= 64'(EXP_TABLE_ENTRIES)) i = 64'(EXP_TABLE_ENTRIES - 1);
            e = (int_rom[n] * frac_rom[i] + (64'd1 << 29)) >> 30;
            e = (e * p + (64'd1 << 29)) >> 30;
        end
        th_h  = th * hm;
        hard  = y + apply_sign(h < 0, scaled_round(th_h, 64'(strain), 40))
                  + apply_sign(dk < 0, scaled_round(dm, (64'd1 << 30) - e, 30))
                  + apply_sign(h < 0, scaled_round((64'd65536 - th) * hm, 64'd1, 16));
        slope = apply_sign(h < 0, scaled_round(th_h, 64'd1, 16))
              + apply_sign(dk < 0, scaled_round(scaled_round(dm, e, 30), 64'(rate_q), 16));
        res.saturated = 1'b0;
        if (hard > OUT_HI) begin hard = OUT_HI; res.saturated = 1'b1; end
        if (hard < OUT_LO) begin hard = OUT_LO; res.saturated = 1'b1; end
        if (slope > OUT_HI) begin slope = OUT_HI; res.saturated = 1'b1; end
        if (slope < OUT_LO) begin slope = OUT_LO; res.saturated = 1'b1; end
        res.hardening = hard[47:0];
        res.slope     = slope[47:0];
        return res;
    endfunction

    initial begin
        logic [63:0] cur, e1;
        cur = 64'd1 << 60;
        e1  = series_exp(64'd1, 64'd1);
        for (int k = 0; k < 33; k++) begin
            int_rom[k] = (cur + (64'd1 << 29)) >> 30;
            cur = q60_product(cur, e1);
        end
        for (int k = 0; k <= EXP_TABLE_ENTRIES; k++)
            frac_rom[k] = (series_exp(64'(k), 64'(EXP_TABLE_ENTRIES)) + (64'd1 << 29)) >> 30;
    end

    // Register write at one rising edge; block must be idle
    task automatic write_reg(input cfg_reg_e idx, input logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_YIELD:    yield_q  = val;
            REG_LINEAR:   linear_q = val;
            REG_REF:      kref_q   = val;
            REG_INF:      kinf_q   = val;
            REG_EXPONENT: rate_q   = val[31:0];
            default:      share_q  = val[16:0];
        endcase
        // derived values settle in the cycle after the write
        @(negedge aclk);
    endtask

    // Stop offering and wait until every result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_stress.size() != 0) @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
    endtask

    // Offer one strain; s_tvalid stays high across back-to-back transfers
    task automatic send_strain(input logic [31:0] strain, input bit typed,
                               input stress_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= strain;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_stress.push_back(typed ? want : predict_stress(strain));
        @(negedge aclk);
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 19) == 0) repeat ($urandom_range(20, 60)) @(negedge aclk);
            else repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
    endtask

    function automatic logic [31:0] random_strain();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 255);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            2:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] random_stress();
        logic [47:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return 48'h7FFF_FFFF_FFFF;
            1:       return 48'h8000_0000_0000;
            2:       return {{24{v[47]}}, v[23:0]};
            3:       return {{36{v[47]}}, v[11:0]};
            default: return v;
        endcase
    endfunction

    function automatic logic [47:0] random_rate();
        case ($urandom_range(0, 4))
            0:       return 48'(32'hFFFF_FFFF);
            1:       return 48'($urandom_range(0, 32'h0010_0000));
            2:       return 48'($urandom_range(0, 255));
            default: return 48'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] random_share();
        case ($urandom_range(0, 4))
            0:       return 48'd65536;
            1:       return 48'd0;
            2:       return 48'(17'h1FFFF - $urandom_range(0, 65535)); // above one
            default: return 48'($urandom_range(0, 65536));
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_long) begin
                m_tready <= 1'b0;
                repeat (60) @(negedge aclk);
                hold_off_long = 1'b0;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                if ($urandom_range(0, 15) == 0) repeat ($urandom_range(10, 40)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Checker at the rising edge
    always @(posedge aclk) begin
        stress_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[47:0], m_tdata[95:48], m_tdata[96]};
            if (pending_stress.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_stress.pop_front();
                if (got.hardening !== want.hardening) begin
                    $error("hardening: expected %h, got %h", want.hardening, got.hardening);
                    fail_count++;
                end
                if (got.slope !== want.slope) begin
                    $error("hardening_slope: expected %h, got %h", want.slope, got.slope);
                    fail_count++;
                end
                if (got.saturated !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated, got.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP) begin
                $display("[voce_hardening_evaluator] ERROR");
                $finish;
            end
        end
    end

    strain_row_t directed[$];
    stress_t     zero_res;

    initial begin
        fail_count    = 0;
        hold_off_long = 1'b0;
        stall_on      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_YIELD;
        cfg_wdata = '0;
        yield_q = '0; linear_q = '0; kref_q = '0; kinf_q = '0;
        rate_q = '0; share_q = 17'd65536;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // After reset every term is zero whatever the strain
        zero_res = '0;
        directed.push_back('{32'd0, 1'b1, zero_res});
        directed.push_back('{32'hFFFF_FFFF, 1'b1, zero_res});
        foreach (directed[k]) send_strain(directed[k].strain, 1'b1, directed[k].want);
        wait_drained();

        // Extremes: large argument, theta above one, positive and negative overflow
        write_reg(REG_YIELD, 48'h0000_0000_1000);
        write_reg(REG_LINEAR, 48'h0000_0100_0000);
        write_reg(REG_REF, 48'h0000_0000_0000);
        write_reg(REG_INF, 48'h0000_0010_0000);
        write_reg(REG_EXPONENT, 48'h0001_0000);      // 1.0
        write_reg(REG_THETA, 48'd65536);
        directed.delete();
        begin
            logic [31:0] pts [8];
            pts = '{32'd0, 32'd1, 32'h0100_0000, 32'h1F00_0000, 32'h2000_0000,
                    32'h2000_0001, 32'hFFFF_FFFF, 32'h0080_0000};
            foreach (pts[k]) send_strain(pts[k], 1'b0, zero_res);
            wait_drained();
            write_reg(REG_THETA, 48'h1FFFF);             // used as one
            write_reg(REG_EXPONENT, 48'hFFFF_FFFF);
            foreach (pts[k]) send_strain(pts[k], 1'b0, zero_res);
            wait_drained();
            write_reg(REG_THETA, 48'd0);
            write_reg(REG_YIELD, 48'h7FFF_FFFF_FFFF);
            write_reg(REG_LINEAR, 48'h7FFF_FFFF_FFFF);
            write_reg(REG_REF, 48'h8000_0000_0000);
            write_reg(REG_INF, 48'h7FFF_FFFF_FFFF);
            foreach (pts[k]) send_strain(pts[k], 1'b0, zero_res);
            wait_drained();
            write_reg(REG_THETA, 48'd32768);
            write_reg(REG_YIELD, 48'h8000_0000_0000);
            write_reg(REG_LINEAR, 48'h8000_0000_0000);
            write_reg(REG_REF, 48'h7FFF_FFFF_FFFF);
            write_reg(REG_INF, 48'h8000_0000_0000);
            foreach (pts[k]) send_strain(pts[k], 1'b0, zero_res);
            wait_drained();
        end

        // Random phases, each with fresh register settings
        stall_on = 1'b1;
        for (int ph = 0; ph < 14; ph++) begin
            write_reg(REG_YIELD, random_stress());
            write_reg(REG_LINEAR, random_stress());
            write_reg(REG_REF, random_stress());
            write_reg(REG_INF, random_stress());
            write_reg(REG_EXPONENT, random_rate());
            write_reg(REG_THETA, random_share());
            if (ph == 3) hold_off_long = 1'b1;   // fills the pipeline, stalls s_tready
            for (int k = 0; k < 72; k++) begin
                if (ph == 3) begin
                    // back-to-back offers while the receiver holds off
                    s_tvalid <= 1'b1;
                    s_tdata  <= random_strain();
                    @(posedge aclk);
                    while (!s_tready) @(posedge aclk);
                    pending_stress.push_back(predict_stress(s_tdata));
                    @(negedge aclk);
                end else begin
                    send_strain(random_strain(), 1'b0, zero_res);
                end
            end
            // sender pauses until every result is back
            wait_drained();
        end

        wait_drained();
        if (fail_count == 0 && pending_stress.size() == 0) begin
            $display("[voce_hardening_evaluator] OK");
        end else begin
            $display("[voce_hardening_evaluator] ERROR");
        end
        $finish;
    end
endmodule
